// ===== hdl/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

   // Arena geometry
   localparam int ARENA_BYTES  = 65536;
   localparam int ALIGN_BYTES  = 16;
   localparam int HEADER_BYTES = 16;
   localparam int ALIGN_LOG2   = $clog2(ALIGN_BYTES);
   localparam int GRANULES     = ARENA_BYTES / ALIGN_BYTES;
   localparam int HDR_GRANULES = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
   localparam int GW           = $clog2(GRANULES + 1);   // granule index incl. null mark
   localparam int IW           = $clog2(GRANULES);       // header store address
   localparam int AWIDTH       = 48;
   localparam int SWIDTH       = 17;

   localparam logic [GW-1:0]     NIL        = GW'(GRANULES);
   localparam logic [SWIDTH-1:0] HEAP_RESET = SWIDTH'(ARENA_BYTES);

   // Request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Configuration register indexes
   localparam logic CSR_BASE_ADDRESS = 1'b0;
   localparam logic CSR_HEAP_SIZE    = 1'b1;

   // Block header kinds (free and used stand for the 0xDEADBEEF / 0xBEEFDEAD tags)
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_FREE = 2'd1,
      KIND_USED = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type        kind;
      logic [GW-1:0]   size;
      logic [GW-1:0]   next;
   } header_type;

   localparam int HDR_W = $bits(header_type);
   localparam header_type HDR_EMPTY = '{kind: KIND_NONE, size: '0, next: '0};

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOSPACE = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   // Pending header writes after a commit
   typedef enum logic [1:0] {
      SLOT_0 = 2'd0,
      SLOT_1 = 2'd1,
      SLOT_2 = 2'd2
   } slot_type;
   localparam int SLOT_COUNT = 3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_A_RD,
      ST_A_EV,
      ST_F_CHKG,
      ST_F_WALK,
      ST_F_STEP,
      ST_F_COMMIT,
      ST_WR0,
      ST_WR1,
      ST_WR2,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       start_walk;
      logic       rd_cur;
      logic       rd_g;
      logic       advance;
      logic       a_commit;
      logic       f_latch_g;
      logic       f_commit;
      logic       wr_go;
      slot_type   wr_slot;
      logic       clr_write;
      logic       set_result;
      status_type result_code;
      logic       out_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_free;
      logic size_zero;
      logic too_big;
      logic addr_null;
      logic off_bad;
      logic cur_nil;
      logic a_fit;
      logic a_split_bad;
      logic g_used;
      logic f_walk_more;
      logic clr_last;
      logic rsp_busy;
      logic rebuild;
   } stat_type;

endpackage

// ===== hdl/ffha_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ffha_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ffha_datapath.sv =====
// Allocator datapath: header store, list pointers, counters and result register.
`timescale 1ns / 1ps
module ffha_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ffha_pkg::cmd_type             cmd,
   output ffha_pkg::stat_type            stat,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [ffha_pkg::AWIDTH-1:0]   csr_wdata,
   input  logic                          req_type,
   input  logic [ffha_pkg::SWIDTH-1:0]   req_size,
   input  logic [ffha_pkg::AWIDTH-1:0]   req_release_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ffha_pkg::AWIDTH-1:0]   rsp_granted_address,
   output logic [1:0]                    rsp_status,
   output logic [ffha_pkg::SWIDTH-1:0]   rsp_bytes_free
);
   import ffha_pkg::*;

   localparam logic [ALIGN_LOG2-1:0] ALIGN_ZERO = '0;

   // Configuration and list state
   logic [AWIDTH-1:0] base_ff,  base_in;
   logic [SWIDTH-1:0] heap_ff,  heap_in;
   logic [GW-1:0]     head_ff,  head_in;
   logic [SWIDTH-1:0] count_ff, count_in;
   logic [IW-1:0]     clr_ff,   clr_in;

   // Request and walk registers
   logic              is_free_ff, is_free_in;
   logic              size_zero_ff, size_zero_in;
   logic              addr_null_ff, addr_null_in;
   logic [AWIDTH-1:0] off_ff, off_in;
   logic [GW-1:0]     ng_ff, ng_in;
   logic [GW-1:0]     cur_ff, cur_in;
   logic [GW-1:0]     prev_ff, prev_in;
   header_type        prev_hdr_ff, prev_hdr_in;
   logic [GW-1:0]     sz_ff, sz_in;

   // Pending writes
   logic              slot_en_ff   [SLOT_COUNT];
   logic              slot_en_in   [SLOT_COUNT];
   logic [IW-1:0]     slot_addr_ff [SLOT_COUNT];
   logic [IW-1:0]     slot_addr_in [SLOT_COUNT];
   header_type        slot_hdr_ff  [SLOT_COUNT];
   header_type        slot_hdr_in  [SLOT_COUNT];

   // Result
   logic [AWIDTH-1:0] granted_ff, granted_in;
   status_type        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [AWIDTH-1:0] rsp_addr_ff, rsp_addr_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [SWIDTH-1:0] rsp_free_ff, rsp_free_in;

   // Header store port
   logic              ram_wr_en;
   logic [IW-1:0]     ram_wr_addr;
   header_type        ram_wr_data;
   logic              ram_rd_en;
   logic [IW-1:0]     ram_rd_addr;
   logic [HDR_W-1:0]  ram_rd_raw;
   header_type        rdata;

   // Derived values
   logic [SWIDTH:0]             size_round;
   logic [GW:0]                 ng_wide;
   logic [GW-1:0]               ng_req;
   logic [GW+ALIGN_LOG2-1:0]    ng_bytes;
   logic [GW+ALIGN_LOG2-1:0]    sz_bytes;
   logic [IW-1:0]               g_w;
   logic [GW-1:0]               g_full;
   logic                        a_equal;
   logic [GW:0]                 nb_sum;
   logic [GW-1:0]               nb;
   logic [GW-1:0]               a_link;
   logic                        prev_nil;
   logic                        merge_before;
   logic                        merge_after;
   header_type                  f_nb_hdr;
   logic [IW-1:0]               f_nb_addr;
   logic                        rebuild;
   logic [SWIDTH-1:0]           hs_sat;
   logic [SWIDTH-1:0]           hs_new;
   logic [GW-1:0]               clr_n;

   ffha_ram #(
      .WIDTH(HDR_W),
      .DEPTH(GRANULES)
   ) u_hdr_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_raw)
   );

   assign rdata = header_type'(ram_rd_raw);

   // Request decode
   assign size_round = {1'b0, req_size} + (SWIDTH + 1)'(ALIGN_BYTES - 1);
   assign ng_wide    = (GW + 1)'(size_round >> ALIGN_LOG2) + (GW + 1)'(HDR_GRANULES);
   // oversized requests saturate so the free-count check rejects them
   assign ng_req     = ng_wide[GW] ? '1 : ng_wide[GW-1:0];
   assign ng_bytes   = {ng_ff, ALIGN_ZERO};
   assign sz_bytes   = {sz_ff, ALIGN_ZERO};
   assign g_w        = off_ff[ALIGN_LOG2 +: IW];
   assign g_full     = {1'b0, g_w};
   assign prev_nil   = (prev_ff == NIL);

   // Allocation split
   assign a_equal = (rdata.size == ng_ff);
   assign nb_sum  = {1'b0, cur_ff} + {1'b0, ng_ff};
   assign nb      = nb_sum[GW-1:0];
   assign a_link  = a_equal ? rdata.next : nb;

   // Free coalescing
   assign merge_before = !prev_nil &&
                         (({1'b0, prev_ff} + {1'b0, prev_hdr_ff.size}) == {1'b0, g_full});
   assign merge_after  = (cur_ff < NIL) &&
                         (({1'b0, g_full} + {1'b0, sz_ff}) == {1'b0, cur_ff});

   always_comb begin
      if (merge_before) begin
         f_nb_addr = prev_ff[IW-1:0];
         f_nb_hdr  = '{kind: prev_hdr_ff.kind, size: prev_hdr_ff.size + sz_ff,
                       next: prev_hdr_ff.next};
      end else begin
         f_nb_addr = g_w;
         f_nb_hdr  = '{kind: KIND_FREE, size: sz_ff, next: cur_ff};
      end
      if (merge_after) begin
         f_nb_hdr.size = f_nb_hdr.size + rdata.size;
         f_nb_hdr.next = rdata.next;
      end
   end

   // Heap size write
   assign rebuild = csr_we && (csr_index == CSR_HEAP_SIZE);
   assign hs_sat  = (csr_wdata[SWIDTH-1:0] > HEAP_RESET) ? HEAP_RESET : csr_wdata[SWIDTH-1:0];
   assign hs_new  = {hs_sat[SWIDTH-1:ALIGN_LOG2], ALIGN_ZERO};
   assign clr_n   = GW'(heap_ff >> ALIGN_LOG2);

   // Header store access
   always_comb begin
      ram_rd_en   = cmd.rd_cur || cmd.rd_g;
      ram_rd_addr = cmd.rd_g ? g_w : cur_ff[IW-1:0];
      if (cmd.clr_write) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = ((clr_ff == '0) && (clr_n != '0)) ?
                       header_type'{kind: KIND_FREE, size: clr_n, next: NIL} : HDR_EMPTY;
      end else begin
         ram_wr_en   = cmd.wr_go && slot_en_ff[cmd.wr_slot];
         ram_wr_addr = slot_addr_ff[cmd.wr_slot];
         ram_wr_data = slot_hdr_ff[cmd.wr_slot];
      end
   end

   // Next-state logic
   always_comb begin
      base_in       = base_ff;
      heap_in       = heap_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      clr_in        = clr_ff;
      is_free_in    = is_free_ff;
      size_zero_in  = size_zero_ff;
      addr_null_in  = addr_null_ff;
      off_in        = off_ff;
      ng_in         = ng_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      prev_hdr_in   = prev_hdr_ff;
      sz_in         = sz_ff;
      slot_en_in    = slot_en_ff;
      slot_addr_in  = slot_addr_ff;
      slot_hdr_in   = slot_hdr_ff;
      granted_in    = granted_ff;
      status_in     = status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;

      // latch request word
      if (cmd.load_req) begin
         is_free_in   = (req_type == REQ_FREE);
         size_zero_in = (req_size == '0);
         addr_null_in = (req_release_address == '0);
         off_in       = req_release_address - base_ff - AWIDTH'(HEADER_BYTES);
         ng_in        = ng_req;
         granted_in   = '0;
      end

      if (cmd.start_walk) begin
         cur_in  = head_ff;
         prev_in = NIL;
      end

      if (cmd.advance) begin
         prev_in     = cur_ff;
         prev_hdr_in = rdata;
         cur_in      = rdata.next;
      end

      if (cmd.f_latch_g) begin
         sz_in = rdata.size;
      end

      // take or split the block found
      if (cmd.a_commit) begin
         slot_en_in[SLOT_0]   = 1'b1;
         slot_addr_in[SLOT_0] = cur_ff[IW-1:0];
         slot_hdr_in[SLOT_0]  = '{kind: KIND_USED, size: ng_ff, next: NIL};
         slot_en_in[SLOT_1]   = !a_equal;
         slot_addr_in[SLOT_1] = nb[IW-1:0];
         slot_hdr_in[SLOT_1]  = '{kind: KIND_FREE, size: rdata.size - ng_ff,
                                  next: rdata.next};
         slot_en_in[SLOT_2]   = !prev_nil;
         slot_addr_in[SLOT_2] = prev_ff[IW-1:0];
         slot_hdr_in[SLOT_2]  = '{kind: prev_hdr_ff.kind, size: prev_hdr_ff.size,
                                  next: a_link};
         if (prev_nil) begin
            head_in = a_link;
         end
         count_in   = count_ff - SWIDTH'(ng_bytes);
         granted_in = base_ff + (AWIDTH'(cur_ff) << ALIGN_LOG2) + AWIDTH'(HEADER_BYTES);
      end

      // insert and coalesce the freed block
      if (cmd.f_commit) begin
         slot_en_in[SLOT_0]   = 1'b1;
         slot_addr_in[SLOT_0] = f_nb_addr;
         slot_hdr_in[SLOT_0]  = f_nb_hdr;
         if (merge_before) begin
            slot_en_in[SLOT_1]   = 1'b1;
            slot_addr_in[SLOT_1] = g_w;
            slot_hdr_in[SLOT_1]  = HDR_EMPTY;
         end else begin
            slot_en_in[SLOT_1]   = !prev_nil;
            slot_addr_in[SLOT_1] = prev_ff[IW-1:0];
            slot_hdr_in[SLOT_1]  = '{kind: prev_hdr_ff.kind, size: prev_hdr_ff.size,
                                     next: g_full};
            if (prev_nil) begin
               head_in = g_full;
            end
         end
         slot_en_in[SLOT_2]   = merge_after;
         slot_addr_in[SLOT_2] = cur_ff[IW-1:0];
         slot_hdr_in[SLOT_2]  = HDR_EMPTY;
         count_in = count_ff + SWIDTH'(sz_bytes);
      end

      if (cmd.set_result) begin
         status_in = cmd.result_code;
      end

      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = granted_ff;
         rsp_status_in = status_ff;
         rsp_free_in   = count_ff;
      end

      if (cmd.clr_write) begin
         clr_in = clr_ff + 1'b1;
      end

      // configuration writes
      if (csr_we && (csr_index == CSR_BASE_ADDRESS)) begin
         base_in = csr_wdata;
      end
      if (rebuild) begin
         heap_in  = hs_new;
         count_in = hs_new;
         head_in  = (hs_new == '0) ? NIL : '0;
         clr_in   = '0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         heap_ff      <= HEAP_RESET;
         head_ff      <= '0;
         count_ff     <= HEAP_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         heap_ff      <= heap_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      is_free_ff    <= is_free_in;
      size_zero_ff  <= size_zero_in;
      addr_null_ff  <= addr_null_in;
      off_ff        <= off_in;
      ng_ff         <= ng_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      prev_hdr_ff   <= prev_hdr_in;
      sz_ff         <= sz_in;
      slot_en_ff    <= slot_en_in;
      slot_addr_ff  <= slot_addr_in;
      slot_hdr_ff   <= slot_hdr_in;
      granted_ff    <= granted_in;
      status_ff     <= status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // Status to controller
   always_comb begin
      stat.is_free     = is_free_ff;
      stat.size_zero   = size_zero_ff;
      stat.too_big     = ng_bytes > (GW + ALIGN_LOG2)'(count_ff);
      stat.addr_null   = addr_null_ff;
      stat.off_bad     = (off_ff >= AWIDTH'(heap_ff)) ||
                         (off_ff[ALIGN_LOG2-1:0] != ALIGN_ZERO);
      stat.cur_nil     = (cur_ff >= NIL);
      stat.a_fit       = (rdata.size >= ng_ff);
      stat.a_split_bad = !a_equal && (nb_sum >= (GW + 1)'(GRANULES));
      stat.g_used      = (rdata.kind == KIND_USED);
      stat.f_walk_more = (cur_ff < NIL) && (cur_ff < g_full);
      stat.clr_last    = (clr_ff == IW'(GRANULES - 1));
      stat.rsp_busy    = rsp_valid_ff && !rsp_ready;
      stat.rebuild     = rebuild;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_bytes_free      = rsp_free_ff;

   // Free count never exceeds the arena in use
   a_count_le_heap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= heap_ff)
      else $error("free byte count above heap size");

   // List head is a granule or the null mark
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= NIL)
      else $error("free list head out of range");

   // A commit never happens while the header store is being cleared
   a_no_commit_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_write |-> !(cmd.a_commit || cmd.f_commit || cmd.wr_go))
      else $error("commit during clearing pass");

endmodule

// ===== hdl/ffha_ctrl.sv =====
// Allocator controller: sequences request decode, list walks and header writes.
`timescale 1ns / 1ps
module ffha_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ffha_pkg::stat_type  stat,
   output ffha_pkg::cmd_type   cmd
);
   import ffha_pkg::*;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:    if (stat.clr_last) state_in = ST_IDLE;
         ST_IDLE:     if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            if (stat.is_free) begin
               if (stat.addr_null || stat.off_bad) state_in = ST_FINISH;
               else state_in = ST_F_CHKG;
            end else begin
               if (stat.size_zero || stat.too_big) state_in = ST_FINISH;
               else state_in = ST_A_RD;
            end
         end
         ST_A_RD:     state_in = stat.cur_nil ? ST_FINISH : ST_A_EV;
         ST_A_EV: begin
            if (!stat.a_fit) state_in = ST_A_RD;
            else if (stat.a_split_bad) state_in = ST_FINISH;
            else state_in = ST_WR0;
         end
         ST_F_CHKG:   state_in = stat.g_used ? ST_F_WALK : ST_FINISH;
         ST_F_WALK:   state_in = stat.f_walk_more ? ST_F_STEP : ST_F_COMMIT;
         ST_F_STEP:   state_in = ST_F_WALK;
         ST_F_COMMIT: state_in = ST_WR0;
         ST_WR0:      state_in = ST_WR1;
         ST_WR1:      state_in = ST_WR2;
         ST_WR2:      state_in = ST_FINISH;
         ST_FINISH:   if (!stat.rsp_busy) state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
      // heap size write restarts the clearing pass
      if (stat.rebuild) state_in = ST_CLEAR;
   end

   // Outputs
   always_comb begin
      cmd             = '0;
      cmd.result_code = STATUS_OK;
      cmd.wr_slot     = SLOT_0;
      req_ready       = 1'b0;
      unique case (state_ff)
         ST_CLEAR:    cmd.clr_write = 1'b1;
         ST_IDLE: begin
            req_ready    = !stat.rebuild;
            cmd.load_req = req_valid && !stat.rebuild;
         end
         ST_DECODE: begin
            if (stat.is_free) begin
               if (stat.addr_null) begin
                  cmd.set_result = 1'b1;
               end else if (stat.off_bad) begin
                  cmd.set_result  = 1'b1;
                  cmd.result_code = STATUS_INVALID;
               end else begin
                  cmd.rd_g = 1'b1;
               end
            end else begin
               if (stat.size_zero || stat.too_big) begin
                  cmd.set_result  = 1'b1;
                  cmd.result_code = STATUS_NOSPACE;
               end else begin
                  cmd.start_walk = 1'b1;
               end
            end
         end
         ST_A_RD: begin
            if (stat.cur_nil) begin
               cmd.set_result  = 1'b1;
               cmd.result_code = STATUS_NOSPACE;
            end else begin
               cmd.rd_cur = 1'b1;
            end
         end
         ST_A_EV: begin
            if (!stat.a_fit) begin
               cmd.advance = 1'b1;
            end else if (stat.a_split_bad) begin
               cmd.set_result  = 1'b1;
               cmd.result_code = STATUS_NOSPACE;
            end else begin
               cmd.a_commit = 1'b1;
            end
         end
         ST_F_CHKG: begin
            if (stat.g_used) begin
               cmd.f_latch_g  = 1'b1;
               cmd.start_walk = 1'b1;
            end else begin
               cmd.set_result  = 1'b1;
               cmd.result_code = STATUS_INVALID;
            end
         end
         ST_F_WALK:   cmd.rd_cur   = 1'b1;
         ST_F_STEP:   cmd.advance  = 1'b1;
         ST_F_COMMIT: cmd.f_commit = 1'b1;
         ST_WR0: begin
            cmd.wr_go   = 1'b1;
            cmd.wr_slot = SLOT_0;
         end
         ST_WR1: begin
            cmd.wr_go   = 1'b1;
            cmd.wr_slot = SLOT_1;
         end
         ST_WR2: begin
            cmd.wr_go      = 1'b1;
            cmd.wr_slot    = SLOT_2;
            cmd.set_result = 1'b1;
         end
         ST_FINISH:   cmd.out_load = !stat.rsp_busy;
         default:     cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted word always goes to decode next
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECODE))
      else $error("accepted word not decoded");

   // The result register is loaded only when it is free to take a word
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (state_ff == ST_FINISH) && !stat.rsp_busy)
      else $error("result loaded over a pending word");

   // No word is taken during the clearing pass
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("word accepted while clearing");

endmodule

// ===== hdl/first_fit_heap_allocator_top.sv =====
// Allocate walks the free list one block at a time until a block fits or the list ends; free reads
//   the released block's header, then walks the free blocks below it; rejects are given at
//   decode or after the first header read.
// A new word is taken only after the previous one has finished; each visited block costs one header read.
// Reset (synchronous, active high) and every heap_size write start a clearing pass
//   over the header store; no request word is taken until it ends.
`timescale 1ns / 1ps
module first_fit_heap_allocator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [ffha_pkg::SWIDTH-1:0]   req_size,
   input  logic [ffha_pkg::AWIDTH-1:0]   req_release_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ffha_pkg::AWIDTH-1:0]   rsp_granted_address,
   output logic [1:0]                    rsp_status,
   output logic [ffha_pkg::SWIDTH-1:0]   rsp_bytes_free,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [ffha_pkg::AWIDTH-1:0]   csr_wdata
);
   import ffha_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ffha_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   ffha_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_type           (req_type),
      .req_size           (req_size),
      .req_release_address(req_release_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_granted_address(rsp_granted_address),
      .rsp_status         (rsp_status),
      .rsp_bytes_free     (rsp_bytes_free)
   );

endmodule
